@@ hw/rtl/dht_pkg.sv @@
// Shared types and constants for the single-wire sensor reader.
// Used by dht_out_buf and dht_single_wire_reader; depends on nothing.
package dht_pkg;

	// Configuration register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_START_LOW     = 3'd0;
	localparam logic [2:0] REG_RESPONSE_LOW  = 3'd1;
	localparam logic [2:0] REG_RESPONSE_HIGH = 3'd2;
	localparam logic [2:0] REG_SAMPLE_DELAY  = 3'd3;
	localparam logic [2:0] REG_EDGE_TIMEOUT  = 3'd4;
	localparam logic [2:0] REG_FRAME_BYTES   = 3'd5;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Register reset values
	localparam logic [15:0] START_LOW_RST     = 16'd18000;
	localparam logic [7:0]  RESPONSE_LOW_RST  = 8'd40;
	localparam logic [7:0]  RESPONSE_HIGH_RST = 8'd80;
	localparam logic [7:0]  SAMPLE_DELAY_RST  = 8'd40;
	localparam logic [15:0] EDGE_TIMEOUT_RST  = 16'd1000;
	localparam logic [3:0]  FRAME_BYTES_RST   = 4'd5;

	// One input word: a tick with a line sample, or a start command
	typedef struct packed {
		logic func;
		logic line_level;
	} in_word_t;

	// One result word
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       response_valid;
		logic       response_ok;
		logic       byte_valid;
		logic [7:0] byte_data;
		logic       last_byte;
		logic       timeout_flag;
	} out_word_t;

	// Status of the output buffer seen by the top level
	typedef struct packed {
		logic can_push;
		logic empty;
	} buf_status_t;

endpackage

@@ hw/rtl/dht_out_buf.sv @@
// Two-entry output buffer that decouples result production from the consumer.
// Depends on dht_pkg (out_word_t, buf_status_t).
module dht_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dht_pkg::out_word_t    push_word,
	output dht_pkg::buf_status_t  status,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output dht_pkg::out_word_t    rsp
);

	dht_pkg::out_word_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop             = rsp_valid && rsp_ready;
	assign rsp_valid       = (count_q != 2'd0);
	assign rsp             = mem_q[rd_ptr_q];
	assign status.can_push = (count_q != 2'd2);
	assign status.empty    = (count_q == 2'd0);

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push)
		else $error("output buffer pushed while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("output buffer pointers disagree with count");

endmodule

@@ hw/rtl/dht_single_wire_reader.sv @@
// Single-wire sensor reader: one word per microsecond tick, one result per word.
// A result is registered in the output buffer when its input word is accepted and is offered from there.
// Throughput: one word per cycle; the two-entry output buffer holds results while
// the consumer stalls, and req_ready drops only when both entries are full.
// Reset (arst_n low, asynchronous): idle phase, counters cleared, bit index seven,
// registers at their defaults, output buffer empty.
module dht_single_wire_reader (
	input  logic                        clk,
	input  logic                        arst_n,
	// APB-style configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dht_pkg::ADDR_W-1:0]  paddr,
	input  logic [dht_pkg::DATA_W-1:0]  pwdata,
	output logic [dht_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// Input words
	input  logic                        req_valid,
	output logic                        req_ready,
	input  dht_pkg::in_word_t           req,
	// Result words
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output dht_pkg::out_word_t          rsp
);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START,
		PH_RESP_LOW,
		PH_RESP_HIGH,
		PH_RESP_FALL,
		PH_BIT_RISE,
		PH_BIT_DELAY,
		PH_BIT_FALL
	} phase_t;

	// Configuration registers
	logic [15:0] start_low_q;
	logic [7:0]  response_low_q;
	logic [7:0]  response_high_q;
	logic [7:0]  sample_delay_q;
	logic [15:0] edge_timeout_q;
	logic [3:0]  frame_bytes_q;

	// Transaction state
	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [2:0]  bit_idx_q, bit_idx_d;
	logic [7:0]  shift_q, shift_d;
	logic [3:0]  byte_cnt_q, byte_cnt_d;
	logic        timed_out_q, timed_out_d;

	logic                 accept;
	logic                 cfg_wr;
	logic [2:0]           cfg_idx;
	dht_pkg::out_word_t   res;
	dht_pkg::buf_status_t buf_st;

	logic [15:0] tick_inc;
	logic [15:0] limit;
	logic        reached;
	logic        bit_done;
	logic [3:0]  byte_cnt_inc;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign cfg_idx   = paddr[4:2];
	assign req_ready = buf_st.can_push;
	assign accept    = req_valid && req_ready;

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q     <= dht_pkg::START_LOW_RST;
			response_low_q  <= dht_pkg::RESPONSE_LOW_RST;
			response_high_q <= dht_pkg::RESPONSE_HIGH_RST;
			sample_delay_q  <= dht_pkg::SAMPLE_DELAY_RST;
			edge_timeout_q  <= dht_pkg::EDGE_TIMEOUT_RST;
			frame_bytes_q   <= dht_pkg::FRAME_BYTES_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				dht_pkg::REG_START_LOW:     start_low_q     <= pwdata[15:0];
				dht_pkg::REG_RESPONSE_LOW:  response_low_q  <= pwdata[7:0];
				dht_pkg::REG_RESPONSE_HIGH: response_high_q <= pwdata[7:0];
				dht_pkg::REG_SAMPLE_DELAY:  sample_delay_q  <= pwdata[7:0];
				dht_pkg::REG_EDGE_TIMEOUT:  edge_timeout_q  <= pwdata[15:0];
				dht_pkg::REG_FRAME_BYTES:   frame_bytes_q   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// Register read
	always_comb begin
		prdata = '0;
		case (cfg_idx)
			dht_pkg::REG_START_LOW:     prdata = {16'd0, start_low_q};
			dht_pkg::REG_RESPONSE_LOW:  prdata = {24'd0, response_low_q};
			dht_pkg::REG_RESPONSE_HIGH: prdata = {24'd0, response_high_q};
			dht_pkg::REG_SAMPLE_DELAY:  prdata = {24'd0, sample_delay_q};
			dht_pkg::REG_EDGE_TIMEOUT:  prdata = {16'd0, edge_timeout_q};
			dht_pkg::REG_FRAME_BYTES:   prdata = {28'd0, frame_bytes_q};
			default:                    prdata = '0;
		endcase
	end

	// Tick counter limit for the current phase; a zero limit acts as one tick
	always_comb begin
		unique case (phase_q)
			PH_START:     limit = start_low_q;
			PH_RESP_LOW:  limit = {8'd0, response_low_q};
			PH_RESP_HIGH: limit = {8'd0, response_high_q};
			PH_BIT_DELAY: limit = {8'd0, sample_delay_q};
			default:      limit = edge_timeout_q;
		endcase
	end

	assign tick_inc     = tick_q + 16'd1;
	assign reached      = (tick_inc >= limit) || (tick_inc == 16'd0);
	assign byte_cnt_inc = byte_cnt_q + 4'd1;

	// Next state and result for one word
	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		bit_idx_d   = bit_idx_q;
		shift_d     = shift_q;
		byte_cnt_d  = byte_cnt_q;
		timed_out_d = timed_out_q;
		bit_done    = 1'b0;
		res         = '0;

		if (req.func) begin
			phase_d     = PH_START;
			tick_d      = '0;
			bit_idx_d   = 3'd7;
			shift_d     = '0;
			byte_cnt_d  = '0;
			timed_out_d = 1'b0;
			res.drive_low = 1'b1;
		end else begin
			unique case (phase_q)
				PH_START: begin
					res.drive_low = 1'b1;
					tick_d = tick_inc;
					if (reached) begin
						phase_d = PH_RESP_LOW;
						tick_d  = '0;
					end
				end
				PH_RESP_LOW: begin
					tick_d = tick_inc;
					if (reached) begin
						tick_d = '0;
						if (!req.line_level) begin
							phase_d = PH_RESP_HIGH;
						end else begin
							res.response_valid = 1'b1;
							phase_d = PH_RESP_FALL;
						end
					end
				end
				PH_RESP_HIGH: begin
					tick_d = tick_inc;
					if (reached) begin
						res.response_valid = 1'b1;
						res.response_ok    = req.line_level;
						phase_d = PH_RESP_FALL;
						tick_d  = '0;
					end
				end
				PH_RESP_FALL: begin
					if (!req.line_level) begin
						phase_d = PH_BIT_RISE;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
						if (reached) begin
							timed_out_d = 1'b1;
							phase_d = PH_BIT_RISE;
							tick_d  = '0;
						end
					end
				end
				PH_BIT_RISE: begin
					if (req.line_level) begin
						phase_d = PH_BIT_DELAY;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
						if (reached) begin
							timed_out_d = 1'b1;
							phase_d = PH_BIT_DELAY;
							tick_d  = '0;
						end
					end
				end
				PH_BIT_DELAY: begin
					tick_d = tick_inc;
					if (reached) begin
						if (req.line_level) shift_d[bit_idx_q] = 1'b1;
						phase_d = PH_BIT_FALL;
						tick_d  = '0;
					end
				end
				PH_BIT_FALL: begin
					if (!req.line_level) begin
						bit_done = 1'b1;
					end else begin
						tick_d = tick_inc;
						if (reached) begin
							timed_out_d = 1'b1;
							bit_done    = 1'b1;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase

			// Bit and byte bookkeeping
			if (bit_done) begin
				if (bit_idx_q == 3'd0) begin
					res.byte_valid = 1'b1;
					res.byte_data  = shift_q;
					byte_cnt_d     = byte_cnt_inc;
					if ((byte_cnt_inc >= frame_bytes_q) || (byte_cnt_inc == 4'd0)) begin
						res.last_byte = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_BIT_RISE;
					end
					tick_d    = '0;
					bit_idx_d = 3'd7;
					shift_d   = '0;
				end else begin
					bit_idx_d = bit_idx_q - 3'd1;
					phase_d   = PH_BIT_RISE;
					tick_d    = '0;
				end
			end
		end

		res.busy_res     = (phase_d != PH_IDLE);
		res.timeout_flag = timed_out_d;
	end

	// State update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_idx_q   <= 3'd7;
			shift_q     <= '0;
			byte_cnt_q  <= '0;
			timed_out_q <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			bit_idx_q   <= bit_idx_d;
			shift_q     <= shift_d;
			byte_cnt_q  <= byte_cnt_d;
			timed_out_q <= timed_out_d;
		end
	end

	dht_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_word (res),
		.status    (buf_st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	a_start_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.func) |=> (phase_q == PH_START && tick_q == 16'd0))
		else $error("start command did not enter start phase");
	a_ok_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.response_ok) |-> res.response_valid)
		else $error("response_ok without response_valid");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.last_byte) |=> (phase_q == PH_IDLE))
		else $error("last byte did not end the transaction");
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.drive_low) |-> res.busy_res)
		else $error("line driven while not busy");

endmodule
